>>> rtl/dct_pkg.sv
// Shared types, codes and character helpers for the condition tokenizer.
`default_nettype none
package dct_pkg;

    localparam int PEND_DEPTH = 5;
    localparam int WORD_DEPTH = 6;

    localparam logic [4:0] K_END        = 5'd0;
    localparam logic [4:0] K_IF         = 5'd1;
    localparam logic [4:0] K_HAS        = 5'd2;
    localparam logic [4:0] K_NOT        = 5'd3;
    localparam logic [4:0] K_TRUE       = 5'd4;
    localparam logic [4:0] K_FALSE      = 5'd5;
    localparam logic [4:0] K_OR         = 5'd6;
    localparam logic [4:0] K_EQ         = 5'd7;
    localparam logic [4:0] K_NEQ        = 5'd8;
    localparam logic [4:0] K_IDENT      = 5'd9;
    localparam logic [4:0] K_NUMBER     = 5'd10;
    localparam logic [4:0] K_STRING     = 5'd11;
    localparam logic [4:0] K_DOT        = 5'd12;
    localparam logic [4:0] K_LBRACE     = 5'd13;
    localparam logic [4:0] K_RBRACE     = 5'd14;
    localparam logic [4:0] K_LINE       = 5'd15;
    localparam logic [4:0] K_BLOCKOPEN  = 5'd16;
    localparam logic [4:0] K_BLOCKCLOSE = 5'd17;
    localparam logic [4:0] K_PAYLOAD    = 5'd18;
    localparam logic [4:0] K_BYTE       = 5'd19;
    localparam logic [4:0] K_ERROR      = 5'd20;

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_WORD = 3'd1;
    localparam logic [2:0] M_NUM  = 3'd2;
    localparam logic [2:0] M_BANG = 3'd3;
    localparam logic [2:0] M_EQ   = 3'd4;
    localparam logic [2:0] M_STR  = 3'd5;

    localparam logic [2:0] R_LINE_PREFIX  = 3'd0;
    localparam logic [2:0] R_LINE_LEN     = 3'd1;
    localparam logic [2:0] R_OPEN_PREFIX  = 3'd2;
    localparam logic [2:0] R_OPEN_LEN     = 3'd3;
    localparam logic [2:0] R_CLOSE_MARKER = 3'd4;
    localparam logic [2:0] R_CLOSE_LEN    = 3'd5;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    localparam logic [30:0] NUM_MAX = 31'h7FFFFFFF;

    typedef struct packed {
        logic [23:0] line_prefix;
        logic [1:0]  line_len;
        logic [23:0] open_prefix;
        logic [1:0]  open_len;
        logic [23:0] close_marker;
        logic [1:0]  close_len;
    } cfg_t;

    typedef struct packed {
        logic       is_end;
        logic [7:0] char_byte;
    } item_t;

    function automatic logic is_space(input logic [7:0] b);
        is_space = b inside {8'h20, [8'd9:8'd13]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        is_alpha = b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic [4:0] word_kind(input logic [5:0][7:0] w, input logic [2:0] n);
        if (n == 3'd2 && w[0] == "i" && w[1] == "f")
            word_kind = K_IF;
        else if (n == 3'd3 && w[0] == "h" && w[1] == "a" && w[2] == "s")
            word_kind = K_HAS;
        else if (n == 3'd3 && w[0] == "n" && w[1] == "o" && w[2] == "t")
            word_kind = K_NOT;
        else if (n == 3'd4 && w[0] == "t" && w[1] == "r" && w[2] == "u" && w[3] == "e")
            word_kind = K_TRUE;
        else if (n == 3'd5 && w[0] == "f" && w[1] == "a" && w[2] == "l" && w[3] == "s"
                 && w[4] == "e")
            word_kind = K_FALSE;
        else
            word_kind = K_IDENT;
    endfunction

endpackage
`default_nettype wire

>>> rtl/dct_front.sv
// Input stage: accepts text transactions, marks the end item and queues them.
`default_nettype none
module dct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        char_in,
    input  logic              end_of_input,
    output logic              q_valid,
    output dct_pkg::item_t    q_item,
    input  logic              q_pop
);
    import dct_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      new_item;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.is_end    = end_of_input;
        new_item.char_byte = end_of_input ? 8'd0 : char_in;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= new_item;
    end

endmodule
`default_nettype wire

>>> rtl/dct_back.sv
// Lexer engine: steps queued bytes through the token rules and emits tokens.
`default_nettype none
module dct_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dct_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  dct_pkg::item_t    q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [4:0]        token_kind,
    output logic [7:0]        byte_value,
    output logic [30:0]       number_value,
    output logic              last_of_run
);
    import dct_pkg::*;

    logic [2:0]       mode_reg, mode_next;
    logic [7:0]       pend_reg [PEND_DEPTH];
    logic [7:0]       pend_next [PEND_DEPTH];
    logic [2:0]       pc_reg, pc_next;
    logic [2:0]       rq_reg, rq_next;
    logic [30:0]      acc_reg, acc_next;
    logic [5:0][7:0]  wp_reg, wp_next;
    logic [2:0]       wl_reg, wl_next;
    logic             err_reg, err_next;
    logic             drain_reg, drain_next;
    logic             res_reg, res_next;
    logic             fin_reg, fin_next;
    logic             busy_reg, busy_next;
    logic             hv_reg, hv_next;
    logic [4:0]       hk_reg, hk_next;
    logic [7:0]       hb_reg, hb_next;
    logic [30:0]      hn_reg, hn_next;
    logic             ov_reg, ov_next;
    logic [4:0]       ok_reg, ok_next;
    logic [7:0]       ob_reg, ob_next;
    logic [30:0]      on_reg, on_next;
    logic             ol_reg, ol_next;

    logic             out_free, go;
    logic             emit;
    logic [4:0]       ek;
    logic [7:0]       eb;
    logic [30:0]      en;
    logic [2:0]       sh;
    logic [7:0]       head;
    logic [34:0]      prod;
    logic [3:0]       si;

    logic [7:0]       mk [4][PEND_DEPTH];
    logic [2:0]       ml [4];
    logic [39:0]      lp_ext, op_ext, cm_ext;
    logic [2:0]       cmp_n;
    logic             match, decided;
    logic             res_wait;
    logic [2:0]       res_take;
    logic [4:0]       res_kind;

    assign out_valid    = ov_reg;
    assign token_kind   = ok_reg;
    assign byte_value   = ob_reg;
    assign number_value = on_reg;
    assign last_of_run  = ol_reg;

    assign head = pend_reg[pc_reg];
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {31'd0, head[3:0]};

    // Marker table and the ordered match against the held lookahead bytes.
    always_comb
    begin
        lp_ext = {16'd0, cfg.line_prefix};
        op_ext = {16'd0, cfg.open_prefix};
        cm_ext = {16'd0, cfg.close_marker};
        ml[0] = {1'b0, cfg.line_len} + 3'd2;
        ml[1] = {1'b0, cfg.line_len} + 3'd1;
        ml[2] = {1'b0, cfg.open_len} + 3'd1;
        ml[3] = {1'b0, cfg.close_len};
        for (int j = 0; j < PEND_DEPTH; j++)
        begin
            mk[0][j] = (3'(j) < {1'b0, cfg.line_len}) ? lp_ext[8*j +: 8] : CH_BANG;
            mk[1][j] = mk[0][j];
            mk[2][j] = (3'(j) < {1'b0, cfg.open_len}) ? op_ext[8*j +: 8] : CH_BANG;
            mk[3][j] = cm_ext[8*j +: 8];
        end
        decided  = 1'b0;
        res_wait = 1'b0;
        res_take = 3'd0;
        res_kind = K_BYTE;
        for (int w = 0; w < 4; w++)
        begin
            cmp_n = (pc_reg < ml[w]) ? pc_reg : ml[w];
            match = 1'b1;
            for (int j = 0; j < PEND_DEPTH; j++)
            begin
                if (3'(j) < cmp_n && pend_reg[j] != mk[w][j])
                    match = 1'b0;
            end
            if (!decided && ml[w] != 3'd0 && match)
            begin
                if (pc_reg >= ml[w])
                begin
                    decided  = 1'b1;
                    res_take = ml[w];
                    case (w)
                        0:       res_kind = K_PAYLOAD;
                        1:       res_kind = K_LINE;
                        2:       res_kind = K_BLOCKOPEN;
                        default: res_kind = K_BLOCKCLOSE;
                    endcase
                end
                else if (!drain_reg)
                begin
                    decided  = 1'b1;
                    res_wait = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        pc_next    = pc_reg;
        rq_next    = rq_reg;
        acc_next   = acc_reg;
        wp_next    = wp_reg;
        wl_next    = wl_reg;
        err_next   = err_reg;
        drain_next = drain_reg;
        res_next   = res_reg;
        fin_next   = fin_reg;
        busy_next  = busy_reg;
        hv_next    = hv_reg;
        hk_next    = hk_reg;
        hb_next    = hb_reg;
        hn_next    = hn_reg;
        ov_next    = ov_reg;
        ok_next    = ok_reg;
        ob_next    = ob_reg;
        on_next    = on_reg;
        ol_next    = ol_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        ek         = K_END;
        eb         = 8'd0;
        en         = 31'd0;
        sh         = 3'd0;
        si         = 4'd0;

        out_free = !ov_reg || !out_stall;
        go       = !hv_reg || out_free;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        if (go)
        begin
            if (!busy_reg)
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    busy_next = 1'b1;
                    if (q_item.is_end)
                    begin
                        res_next   = 1'b1;
                        drain_next = 1'b1;
                        fin_next   = 1'b0;
                    end
                    else if (pc_reg < 3'(PEND_DEPTH))
                    begin
                        pend_next[pc_reg] = q_item.char_byte;
                        rq_next = 3'd1;
                    end
                end
            end
            else if (res_reg)
            begin
                res_next = 1'b0;
                if (pc_reg != 3'd0 && !err_reg && !res_wait)
                begin
                    emit = 1'b1;
                    if (res_take == 3'd0)
                    begin
                        ek = K_BYTE;
                        eb = pend_reg[0];
                        sh = 3'd1;
                    end
                    else
                    begin
                        ek = res_kind;
                        sh = res_take;
                    end
                    rq_next = rq_reg + pc_reg - sh;
                    pc_next = 3'd0;
                end
            end
            else if (rq_reg != 3'd0)
            begin
                if (err_reg)
                    rq_next = 3'd0;
                else
                begin
                    case (mode_reg)
                        M_WORD:
                        begin
                            if (is_alpha(head) || is_digit(head))
                            begin
                                if (wl_reg < 3'(WORD_DEPTH))
                                begin
                                    wp_next[wl_reg] = head;
                                    wl_next = wl_reg + 3'd1;
                                end
                                sh = 3'd1;
                                rq_next = rq_reg - 3'd1;
                            end
                            else
                            begin
                                emit = 1'b1;
                                ek = word_kind(wp_reg, wl_reg);
                                mode_next = M_IDLE;
                            end
                        end
                        M_NUM:
                        begin
                            if (is_digit(head))
                            begin
                                if (prod > {4'd0, NUM_MAX})
                                begin
                                    emit = 1'b1;
                                    ek = K_ERROR;
                                    err_next = 1'b1;
                                    mode_next = M_IDLE;
                                    pc_next = 3'd0;
                                    rq_next = 3'd0;
                                end
                                else
                                begin
                                    acc_next = prod[30:0];
                                    sh = 3'd1;
                                    rq_next = rq_reg - 3'd1;
                                end
                            end
                            else
                            begin
                                emit = 1'b1;
                                ek = K_NUMBER;
                                en = acc_reg;
                                mode_next = M_IDLE;
                            end
                        end
                        M_BANG, M_EQ:
                        begin
                            emit = 1'b1;
                            mode_next = M_IDLE;
                            if (head == CH_EQUAL)
                            begin
                                ek = (mode_reg == M_BANG) ? K_NEQ : K_EQ;
                                sh = 3'd1;
                                rq_next = rq_reg - 3'd1;
                            end
                            else
                            begin
                                ek = K_ERROR;
                                err_next = 1'b1;
                                pc_next = 3'd0;
                                rq_next = 3'd0;
                            end
                        end
                        M_STR:
                        begin
                            if (head == CH_QUOTE)
                            begin
                                emit = 1'b1;
                                ek = K_STRING;
                                mode_next = M_IDLE;
                            end
                            sh = 3'd1;
                            rq_next = rq_reg - 3'd1;
                        end
                        default:
                        begin
                            sh = 3'd1;
                            rq_next = rq_reg - 3'd1;
                            if (pc_reg != 3'd0)
                            begin
                                sh = 3'd0;
                                pc_next = pc_reg + 3'd1;
                                res_next = 1'b1;
                            end
                            else if (is_space(head))
                            begin
                            end
                            else if (is_alpha(head))
                            begin
                                mode_next = M_WORD;
                                wp_next[0] = head;
                                wl_next = 3'd1;
                            end
                            else if (is_digit(head))
                            begin
                                mode_next = M_NUM;
                                acc_next = {27'd0, head[3:0]};
                            end
                            else
                            begin
                                case (head)
                                    CH_DOT:
                                    begin
                                        emit = 1'b1;
                                        ek = K_DOT;
                                    end
                                    CH_LBRACE:
                                    begin
                                        emit = 1'b1;
                                        ek = K_LBRACE;
                                    end
                                    CH_RBRACE:
                                    begin
                                        emit = 1'b1;
                                        ek = K_RBRACE;
                                    end
                                    CH_BAR:
                                    begin
                                        emit = 1'b1;
                                        ek = K_OR;
                                    end
                                    CH_BANG:   mode_next = M_BANG;
                                    CH_EQUAL:  mode_next = M_EQ;
                                    CH_QUOTE:  mode_next = M_STR;
                                    default:
                                    begin
                                        sh = 3'd0;
                                        pc_next = pc_reg + 3'd1;
                                        res_next = 1'b1;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            else if (drain_reg)
            begin
                if (!fin_reg)
                begin
                    fin_next = 1'b1;
                    if (!err_reg)
                    begin
                        if (mode_reg == M_WORD)
                        begin
                            emit = 1'b1;
                            ek = word_kind(wp_reg, wl_reg);
                        end
                        else if (mode_reg == M_NUM)
                        begin
                            emit = 1'b1;
                            ek = K_NUMBER;
                            en = acc_reg;
                        end
                        else if (mode_reg != M_IDLE)
                        begin
                            emit = 1'b1;
                            ek = K_ERROR;
                        end
                    end
                end
                else
                begin
                    emit = 1'b1;
                    ek = K_END;
                    mode_next  = M_IDLE;
                    pc_next    = 3'd0;
                    rq_next    = 3'd0;
                    acc_next   = 31'd0;
                    wl_next    = 3'd0;
                    err_next   = 1'b0;
                    drain_next = 1'b0;
                    fin_next   = 1'b0;
                end
            end
            else
            begin
                busy_next = 1'b0;
                if (hv_reg)
                begin
                    hv_next = 1'b0;
                    ov_next = 1'b1;
                    ok_next = hk_reg;
                    ob_next = hb_reg;
                    on_next = hn_reg;
                    ol_next = 1'b1;
                end
            end

            if (emit)
            begin
                if (hv_reg)
                begin
                    ov_next = 1'b1;
                    ok_next = hk_reg;
                    ob_next = hb_reg;
                    on_next = hn_reg;
                    ol_next = 1'b0;
                end
                hv_next = 1'b1;
                hk_next = ek;
                hb_next = eb;
                hn_next = en;
            end

            if (sh != 3'd0)
            begin
                for (int i = 0; i < PEND_DEPTH; i++)
                begin
                    si = 4'(i) + {1'b0, sh};
                    if (si < 4'(PEND_DEPTH))
                        pend_next[i] = pend_reg[si[2:0]];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pc_reg    <= 3'd0;
            rq_reg    <= 3'd0;
            acc_reg   <= 31'd0;
            wl_reg    <= 3'd0;
            err_reg   <= 1'b0;
            drain_reg <= 1'b0;
            res_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            hv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pc_reg    <= pc_next;
            rq_reg    <= rq_next;
            acc_reg   <= acc_next;
            wl_reg    <= wl_next;
            err_reg   <= err_next;
            drain_reg <= drain_next;
            res_reg   <= res_next;
            fin_reg   <= fin_next;
            busy_reg  <= busy_next;
            hv_reg    <= hv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        wp_reg   <= wp_next;
        hk_reg   <= hk_next;
        hb_reg   <= hb_next;
        hn_reg   <= hn_next;
        ok_reg   <= ok_next;
        ob_reg   <= ob_next;
        on_reg   <= on_next;
        ol_reg   <= ol_next;
    end

endmodule
`default_nettype wire

>>> rtl/dsl_condition_tokenizer.sv
// Top level of the condition tokenizer: configuration registers, front and back parts.
//
// Input channel: one transaction carries a text byte (char_in) or, with
// end_of_input high, the end mark. It is taken when in_valid is high and
// in_stall is low. A two-entry queue sits behind the input.
// Output channel: one transaction per token, taken when out_valid is high and
// out_stall is low. last_of_run marks the final token caused by one input item.
// Configuration: cfg_index selects a register, cfg_data carries its value;
// cfg_ready is always high. Write only while the block is idle.
// Flow: the lexer engine does one step per cycle unless its hold register and
// output register are full and the receiver stalls. A byte that ends a word or
// number is scanned again once its token is emitted, and held lookahead bytes
// are scanned again once the lookahead resolves. Each token is held until the
// next one is known, and then it moves to the output register.
// Reset clears the lexer state and loads the default comment markers.
// When the receiver stalls, the engine stops once its hold register and the
// output register are full, and the input queue then fills and stalls.
`default_nettype none
module dsl_condition_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [7:0]  byte_value,
    output logic [30:0] number_value,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import dct_pkg::*;

    cfg_t  cfg_reg;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_prefix  <= 24'd12079;
            cfg_reg.line_len     <= 2'd2;
            cfg_reg.open_prefix  <= 24'd10799;
            cfg_reg.open_len     <= 2'd2;
            cfg_reg.close_marker <= 24'd12074;
            cfg_reg.close_len    <= 2'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                R_LINE_PREFIX:  cfg_reg.line_prefix  <= cfg_data;
                R_LINE_LEN:     cfg_reg.line_len     <= cfg_data[1:0];
                R_OPEN_PREFIX:  cfg_reg.open_prefix  <= cfg_data;
                R_OPEN_LEN:     cfg_reg.open_len     <= cfg_data[1:0];
                R_CLOSE_MARKER: cfg_reg.close_marker <= cfg_data;
                R_CLOSE_LEN:    cfg_reg.close_len    <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    dct_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .end_of_input (end_of_input),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    dct_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .byte_value   (byte_value),
        .number_value (number_value),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire

>>> dv/dsl_condition_tokenizer_test.sv
// Self-checking testbench for the condition tokenizer: directed and random text streams.
`timescale 1ns / 100ps
`default_nettype none

class token_scoreboard;
    logic [23:0] line_pfx;
    logic [1:0]  line_len;
    logic [23:0] open_pfx;
    logic [1:0]  open_len;
    logic [23:0] close_mk;
    logic [1:0]  close_len;

    logic [2:0]       mode;
    logic [7:0]       held [5];
    int               held_n;
    logic [31:0]      accum;
    logic [7:0]       word [6];
    int               word_n;
    bit               err;
    bit               at_end;

    logic [4:0]  exp_kind [$];
    logic [7:0]  exp_byte [$];
    logic [30:0] exp_num [$];
    logic        exp_last [$];
    int          errors;

    function new();
        line_pfx = 24'h002F2F;
        line_len = 2'd2;
        open_pfx = 24'h002A2F;
        open_len = 2'd2;
        close_mk = 24'h002F2A;
        close_len = 2'd2;
        errors = 0;
        clear_lexer();
    endfunction

    function void clear_lexer();
        mode = dct_pkg::M_IDLE;
        held_n = 0;
        accum = 0;
        word_n = 0;
        err = 0;
        at_end = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            dct_pkg::R_LINE_PREFIX:  line_pfx = val;
            dct_pkg::R_LINE_LEN:     line_len = val[1:0];
            dct_pkg::R_OPEN_PREFIX:  open_pfx = val;
            dct_pkg::R_OPEN_LEN:     open_len = val[1:0];
            dct_pkg::R_CLOSE_MARKER: close_mk = val;
            dct_pkg::R_CLOSE_LEN:    close_len = val[1:0];
            default: ;
        endcase
    endfunction

    function void push_token(logic [4:0] k, logic [7:0] b, logic [30:0] n);
        exp_kind = {exp_kind, k};
        exp_byte = {exp_byte, b};
        exp_num = {exp_num, n};
        exp_last = {exp_last, 1'b0};
    endfunction

    function void raise_error();
        push_token(dct_pkg::K_ERROR, 8'd0, 31'd0);
        err = 1;
        mode = dct_pkg::M_IDLE;
        held_n = 0;
    endfunction

    function logic [4:0] classify_word();
        if (word_n == 2 && word[0] == "i" && word[1] == "f") return dct_pkg::K_IF;
        if (word_n == 3 && word[0] == "h" && word[1] == "a" && word[2] == "s")
            return dct_pkg::K_HAS;
        if (word_n == 3 && word[0] == "n" && word[1] == "o" && word[2] == "t")
            return dct_pkg::K_NOT;
        if (word_n == 4 && word[0] == "t" && word[1] == "r" && word[2] == "u"
            && word[3] == "e") return dct_pkg::K_TRUE;
        if (word_n == 5 && word[0] == "f" && word[1] == "a" && word[2] == "l"
            && word[3] == "s" && word[4] == "e") return dct_pkg::K_FALSE;
        return dct_pkg::K_IDENT;
    endfunction

    function int build_marker(int w, output logic [7:0] m [5]);
        logic [23:0] r;
        int          n;
        int          len;
        for (int i = 0; i < 5; i++) m[i] = 8'd0;
        if (w <= 1) begin r = line_pfx; len = int'(line_len); end
        else if (w == 2) begin r = open_pfx; len = int'(open_len); end
        else begin r = close_mk; len = int'(close_len); end
        n = (len < 3) ? len : 3;
        for (int i = 0; i < n; i++) m[i] = r[8*i +: 8];
        if (w <= 2) begin m[n] = dct_pkg::CH_BANG; n++; end
        if (w == 0) begin m[n] = dct_pkg::CH_BANG; n++; end
        return n;
    endfunction

    function void settle_lookahead();
        logic [7:0] m [5];
        logic [7:0] rest [5];
        logic [4:0] kind;
        int         take;
        int         len;
        int         n;
        int         rn;
        bit         same;
        take = 0;
        kind = dct_pkg::K_BYTE;
        if (held_n == 0 || err) return;
        for (int w = 0; w < 4; w++) begin
            len = build_marker(w, m);
            if (len == 0) continue;
            n = (held_n < len) ? held_n : len;
            same = 1;
            for (int i = 0; i < n; i++) if (held[i] != m[i]) same = 0;
            if (!same) continue;
            if (held_n >= len) begin
                take = len;
                case (w)
                    0: kind = dct_pkg::K_PAYLOAD;
                    1: kind = dct_pkg::K_LINE;
                    2: kind = dct_pkg::K_BLOCKOPEN;
                    default: kind = dct_pkg::K_BLOCKCLOSE;
                endcase
                break;
            end
            if (!at_end) return;
        end
        if (take == 0) begin
            push_token(dct_pkg::K_BYTE, held[0], 31'd0);
            take = 1;
        end else begin
            push_token(kind, 8'd0, 31'd0);
        end
        rn = held_n - take;
        for (int i = 0; i < rn; i++) rest[i] = held[take + i];
        held_n = 0;
        for (int i = 0; i < rn; i++) lex_byte(rest[i]);
    endfunction

    function void lex_byte(logic [7:0] b);
        logic [34:0] v;
        if (err) return;
        if (mode == dct_pkg::M_WORD) begin
            if (dct_pkg::is_alpha(b) || dct_pkg::is_digit(b)) begin
                if (word_n < 6) begin word[word_n] = b; word_n++; end
                return;
            end
            push_token(classify_word(), 8'd0, 31'd0);
            mode = dct_pkg::M_IDLE;
        end else if (mode == dct_pkg::M_NUM) begin
            if (dct_pkg::is_digit(b)) begin
                v = {3'd0, accum} * 35'd10 + {27'd0, b - 8'h30};
                if (v > 35'h7FFFFFFF) raise_error();
                else accum = v[31:0];
                return;
            end
            push_token(dct_pkg::K_NUMBER, 8'd0, accum[30:0]);
            mode = dct_pkg::M_IDLE;
        end else if (mode == dct_pkg::M_BANG || mode == dct_pkg::M_EQ) begin
            if (b == dct_pkg::CH_EQUAL) begin
                push_token(mode == dct_pkg::M_BANG ? dct_pkg::K_NEQ : dct_pkg::K_EQ,
                           8'd0, 31'd0);
                mode = dct_pkg::M_IDLE;
            end else begin
                raise_error();
            end
            return;
        end else if (mode == dct_pkg::M_STR) begin
            if (b == dct_pkg::CH_QUOTE) begin
                push_token(dct_pkg::K_STRING, 8'd0, 31'd0);
                mode = dct_pkg::M_IDLE;
            end
            return;
        end
        if (held_n == 0) begin
            if (dct_pkg::is_space(b)) return;
            if (dct_pkg::is_alpha(b)) begin
                mode = dct_pkg::M_WORD; word[0] = b; word_n = 1; return;
            end
            if (dct_pkg::is_digit(b)) begin
                mode = dct_pkg::M_NUM; accum = {24'd0, b - 8'h30}; return;
            end
            case (b)
                dct_pkg::CH_DOT:    begin push_token(dct_pkg::K_DOT, 8'd0, 31'd0); return; end
                dct_pkg::CH_LBRACE: begin push_token(dct_pkg::K_LBRACE, 8'd0, 31'd0); return; end
                dct_pkg::CH_RBRACE: begin push_token(dct_pkg::K_RBRACE, 8'd0, 31'd0); return; end
                dct_pkg::CH_BAR:    begin push_token(dct_pkg::K_OR, 8'd0, 31'd0); return; end
                dct_pkg::CH_BANG:   begin mode = dct_pkg::M_BANG; return; end
                dct_pkg::CH_EQUAL:  begin mode = dct_pkg::M_EQ; return; end
                dct_pkg::CH_QUOTE:  begin mode = dct_pkg::M_STR; return; end
                default: ;
            endcase
        end
        if (held_n < 5) begin held[held_n] = b; held_n++; end
        settle_lookahead();
    endfunction

    function void note_input(logic eoi, logic [7:0] ch);
        int before_n;
        before_n = exp_kind.size();
        if (eoi) begin
            at_end = 1;
            settle_lookahead();
            if (!err) begin
                if (mode == dct_pkg::M_WORD) push_token(classify_word(), 8'd0, 31'd0);
                else if (mode == dct_pkg::M_NUM)
                    push_token(dct_pkg::K_NUMBER, 8'd0, accum[30:0]);
                else if (mode != dct_pkg::M_IDLE) raise_error();
            end
            push_token(dct_pkg::K_END, 8'd0, 31'd0);
            clear_lexer();
        end else begin
            lex_byte(ch);
        end
        if (exp_kind.size() > before_n) exp_last[exp_last.size() - 1] = 1'b1;
    endfunction

    function void check_token(logic [4:0] k, logic [7:0] b, logic [30:0] n, logic l);
        logic [4:0]  ek;
        logic [7:0]  eb;
        logic [30:0] en;
        logic        el;
        if (exp_kind.size() == 0) begin
            $display("%0t: unexpected token kind=%0d byte=%0d num=%0d last=%0d",
                     $time, k, b, n, l);
            errors++;
            return;
        end
        ek = exp_kind.pop_front();
        eb = exp_byte.pop_front();
        en = exp_num.pop_front();
        el = exp_last.pop_front();
        if (k !== ek) begin
            $display("%0t: token_kind expected %0d actual %0d", $time, ek, k); errors++;
        end
        if (b !== eb) begin
            $display("%0t: byte_value expected %0d actual %0d", $time, eb, b); errors++;
        end
        if (n !== en) begin
            $display("%0t: number_value expected %0d actual %0d", $time, en, n); errors++;
        end
        if (l !== el) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time, el, l); errors++;
        end
    endfunction

    function int pending();
        return exp_kind.size();
    endfunction
endclass

module dsl_condition_tokenizer_test;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_in;
    logic        end_of_input;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  token_kind;
    logic [7:0]  byte_value;
    logic [30:0] number_value;
    logic        last_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    token_scoreboard tokens;
    bit              quiet_sender;
    bit              quiet_receiver;
    bit              hold_receiver;

    dsl_condition_tokenizer u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .char_in(char_in), .end_of_input(end_of_input),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .byte_value(byte_value),
        .number_value(number_value), .last_of_run(last_of_run),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tokens.check_token(token_kind, byte_value, number_value, last_of_run);
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_receiver) out_stall <= 1'b1;
            else if (quiet_receiver) out_stall <= 1'b0;
            else out_stall <= ($urandom_range(99) < 26);
        end
    end

    // The valid line stays high after a transaction so that items can follow
    // back to back; callers drop it once a sequence is complete.
    task automatic send_item(input logic eoi, input logic [7:0] ch);
        while (!quiet_sender && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in <= ch;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tokens.note_input(eoi, ch);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    task automatic drain();
        while (tokens.pending() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tokens.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        logic [7:0] alphabet [20];
        alphabet = '{"/", "*", "!", "=", "i", "f", "t", "r", "u", "e", "a", "9", "0",
                     " ", ".", "{", "}", "|", "\"", "#"};
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return alphabet[$urandom_range(19)];
    endfunction

    task automatic random_items(input int count);
        int n;
        for (int i = 0; i < count; i++)
        begin
            n = $urandom_range(99);
            if (n < 8) send_item(1'b1, 8'($urandom_range(255)));
            else if (n < 14) send_text("has not false true if ");
            else if (n < 18) send_text("2147483647 ");
            else send_item(1'b0, pick_char());
        end
        send_item(1'b1, 8'd0);
        in_valid <= 1'b0;
    endtask

    initial
    begin
        tokens = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_in = 8'd0;
        end_of_input = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = dct_pkg::R_LINE_PREFIX;
        cfg_data = 24'd0;
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        hold_receiver = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_text("if has not true false x1 | == != . { } \"s\" 0 2147483647");
        send_item(1'b1, 8'd0);
        send_text("//! //!! /*! */ @ 2147483648");
        send_item(1'b1, 8'd0);
        send_text("! x"); send_item(1'b1, 8'd0);
        send_text("=");   send_item(1'b1, 8'd0);
        send_text("\"ab");  send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'hFF); send_item(1'b0, 8'h00); send_item(1'b1, 8'd0);
        in_valid <= 1'b0;
        drain();

        random_items(40);
        drain();

        write_reg(dct_pkg::R_LINE_PREFIX, 24'h232323);
        write_reg(dct_pkg::R_LINE_LEN, 24'd3);
        write_reg(dct_pkg::R_OPEN_PREFIX, 24'hFFFFFF);
        write_reg(dct_pkg::R_OPEN_LEN, 24'd0);
        write_reg(dct_pkg::R_CLOSE_MARKER, 24'h2A2A2A);
        write_reg(dct_pkg::R_CLOSE_LEN, 24'd3);
        quiet_sender = 1'b1;
        quiet_receiver = 1'b1;
        send_text("###!! ###! ! *** **");
        random_items(20);
        quiet_sender = 1'b0;
        quiet_receiver = 1'b0;
        drain();

        write_reg(dct_pkg::R_LINE_PREFIX, 24'h000000);
        write_reg(dct_pkg::R_LINE_LEN, 24'd1);
        write_reg(dct_pkg::R_OPEN_PREFIX, 24'h00002F);
        write_reg(dct_pkg::R_OPEN_LEN, 24'd1);
        write_reg(dct_pkg::R_CLOSE_MARKER, 24'hFFFF2F);
        write_reg(dct_pkg::R_CLOSE_LEN, 24'd0);
        fork
            begin
                hold_receiver = 1'b1;
                repeat (300) @(negedge clk);
                hold_receiver = 1'b0;
            end
            random_items(40);
        join
        drain();

        write_reg(dct_pkg::R_LINE_PREFIX, 24'h002F2F);
        write_reg(dct_pkg::R_LINE_LEN, 24'd2);
        write_reg(dct_pkg::R_OPEN_PREFIX, 24'h002A2F);
        write_reg(dct_pkg::R_OPEN_LEN, 24'd2);
        write_reg(dct_pkg::R_CLOSE_MARKER, 24'h00002A);
        write_reg(dct_pkg::R_CLOSE_LEN, 24'd1);
        random_items(40);
        drain();

        if (tokens.errors == 0 && tokens.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
